/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/scc_pkg.sv */
// shared constants, command and status types for the component search
package scc_pkg;
    localparam int MAX_V    = 64;
    localparam int MAX_E    = 256;
    localparam int VW       = $clog2(MAX_V);
    localparam int CNT_W    = VW + 1;
    localparam int EAW      = $clog2(MAX_E);
    localparam int ECW      = EAW + 1;
    localparam int EDGE_W   = 2 * VW;
    localparam int STK_W    = VW + ECW;
    localparam int FIELD_W  = 7;

    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD_EDGE,
        OP_RUN_INIT,
        OP_FWD_START,
        OP_FWD_SKIP,
        OP_SCAN,
        OP_NEXT_EDGE,
        OP_PUSH,
        OP_COMP_RD,
        OP_LABEL_CHK,
        OP_POP,
        OP_RESTORE,
        OP_TR_INIT,
        OP_TR_RD,
        OP_TR_START,
        OP_ANS,
        OP_OUT_RD,
        OP_OUT_LD,
        OP_OUT_NEXT,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic edge_end;
        logic match;
        logic w_marked;
        logic pass_fwd;
        logic sp_one;
        logic iv_done;
        logic start_free;
        logic i_zero;
        logic u_has;
        logic out_taken;
        logic out_final;
    } dp_stat_t;
endpackage

/* hw/rtl/strongly_connected_components_core.sv */
// top level of the strongly connected component search engine
// edge load requests are accepted every cycle while the controller is idle
// a run request scans the edge store once per stack frame in each of two depth
// first passes, checking each edge and the label of each labelled neighbor,
// then offers each vertex result in turn until taken; input held off
// asynchronous active low reset: empty edge store, vertex count 64
module strongly_connected_components_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write: vertex count
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scc_pkg::FIELD_W-1:0]   cfg_data,
    // input requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [scc_pkg::FIELD_W-1:0]   src_vertex,
    input  logic [scc_pkg::FIELD_W-1:0]   dst_vertex,
    input  logic [1:0]                    direction,
    // per-vertex results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [scc_pkg::VW-1:0]        vertex_index,
    output logic [scc_pkg::VW-1:0]        component_label,
    output logic [scc_pkg::CNT_W-1:0]     component_total,
    output logic [scc_pkg::CNT_W-1:0]     min_sink_volume,
    output logic [scc_pkg::CNT_W-1:0]     answer,
    output logic                          last
);
    import scc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // vertex count register always writable; user must change it only in idle
    assign cfg_ready = 1'b1;

    // controller walks both passes through the shared edge store
    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath holds the stores, the walk stack and the output register
    scc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .src_vertex      (src_vertex),
        .dst_vertex      (dst_vertex),
        .direction       (direction),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .vertex_index    (vertex_index),
        .component_label (component_label),
        .component_total (component_total),
        .min_sink_volume (min_sink_volume),
        .answer          (answer),
        .last            (last)
    );
endmodule

/* hw/rtl/scc_ram.sv */
// generic single write port ram with registered read
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hw/rtl/scc_datapath.sv */
// datapath: edge store, walk stack, finish order, labels and counters
module scc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scc_pkg::dp_cmd_t              cmd,
    output scc_pkg::dp_stat_t             stat,
    input  logic [scc_pkg::FIELD_W-1:0]   src_vertex,
    input  logic [scc_pkg::FIELD_W-1:0]   dst_vertex,
    input  logic [1:0]                    direction,
    input  logic                          cfg_valid,
    input  logic [scc_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [scc_pkg::VW-1:0]        vertex_index,
    output logic [scc_pkg::VW-1:0]        component_label,
    output logic [scc_pkg::CNT_W-1:0]     component_total,
    output logic [scc_pkg::CNT_W-1:0]     min_sink_volume,
    output logic [scc_pkg::CNT_W-1:0]     answer,
    output logic                          last
);
    import scc_pkg::*;

    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_V);
    localparam logic [ECW-1:0]   E_MAX = ECW'(MAX_E);

    logic [CNT_W-1:0] n_reg;
    logic [ECW-1:0]   edge_total_reg;
    logic [CNT_W-1:0] finish_total_reg;
    logic [CNT_W-1:0] comp_cnt_reg;
    logic [CNT_W-1:0] sp_reg;
    logic [VW-1:0]    cur_v_reg;
    logic [ECW-1:0]   cur_e_reg;
    logic [CNT_W-1:0] iv_reg;
    logic [CNT_W-1:0] fi_reg;
    logic [VW-1:0]    ov_reg;
    logic [CNT_W-1:0] vol_reg;
    logic             sink_reg;
    logic [CNT_W-1:0] min_reg;
    logic             has_sink_reg;
    logic [CNT_W-1:0] ans_reg;
    logic             pass_fwd_reg;
    logic [MAX_V-1:0] seen_reg;
    logic [MAX_V-1:0] has_reg;
    logic             out_valid_reg;

    // edge store
    logic              e_we;
    logic [EAW-1:0]    e_waddr;
    logic [EDGE_W-1:0] e_wdata;
    logic [EDGE_W-1:0] e_rdata;
    // stack
    logic              s_we;
    logic              s_re;
    logic [VW-1:0]     s_waddr;
    logic [VW-1:0]     s_raddr;
    logic [STK_W-1:0]  s_rdata;
    // finish order
    logic              f_we;
    logic              f_re;
    logic [VW-1:0]     f_rdata;
    // vertex labels
    logic              c_we;
    logic              c_re;
    logic [VW-1:0]     c_waddr;
    logic [VW-1:0]     c_raddr;
    logic [VW-1:0]     c_rdata;

    logic [VW-1:0]     e_src;
    logic [VW-1:0]     e_dst;
    logic [VW-1:0]     w;
    logic              usable;
    logic              add_ok;
    logic [CNT_W-1:0]  cfg_clamped;
    logic              out_fire;

    assign e_src  = e_rdata[EDGE_W-1:VW];
    assign e_dst  = e_rdata[VW-1:0];
    assign w      = pass_fwd_reg ? e_dst : e_src;
    assign usable = ({1'b0, e_src} < n_reg) && ({1'b0, e_dst} < n_reg);
    assign out_fire = out_valid_reg && out_ready;

    assign add_ok = (src_vertex != '0) && (src_vertex <= n_reg)
                 && (dst_vertex != '0) && (dst_vertex <= n_reg)
                 && (edge_total_reg < E_MAX)
                 && ((direction == DIR_FWD) || (direction == DIR_REV));

    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = CNT_W'(1);
        else if (cfg_data > N_MAX)
            cfg_clamped = N_MAX;
        else
            cfg_clamped = cfg_data;
    end

    // memory port control
    always_comb
    begin
        logic [FIELD_W-1:0] a1;
        logic [FIELD_W-1:0] b1;
        logic [CNT_W-1:0]   spm1;
        logic [CNT_W-1:0]   spm2;
        a1   = src_vertex - FIELD_W'(1);
        b1   = dst_vertex - FIELD_W'(1);
        spm1 = sp_reg - CNT_W'(1);
        spm2 = sp_reg - CNT_W'(2);
        e_we    = (cmd.op == OP_ADD_EDGE) && add_ok;
        e_waddr = edge_total_reg[EAW-1:0];
        e_wdata = (direction == DIR_FWD) ? {a1[VW-1:0], b1[VW-1:0]}
                                         : {b1[VW-1:0], a1[VW-1:0]};
        s_we    = (cmd.op == OP_PUSH);
        s_waddr = spm1[VW-1:0];
        s_re    = (cmd.op == OP_POP);
        s_raddr = spm2[VW-1:0];
        f_we    = (cmd.op == OP_POP) && pass_fwd_reg && (finish_total_reg < N_MAX);
        f_re    = (cmd.op == OP_TR_RD);
        c_we    = ((cmd.op == OP_PUSH) && !pass_fwd_reg) || (cmd.op == OP_TR_START);
        c_waddr = (cmd.op == OP_TR_START) ? f_rdata : w;
        c_re    = (cmd.op == OP_COMP_RD) || (cmd.op == OP_OUT_RD);
        c_raddr = (cmd.op == OP_OUT_RD) ? ov_reg : w;
    end

    scc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_E)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (cmd.op == OP_SCAN),
        .raddr (cur_e_reg[EAW-1:0]),
        .rdata (e_rdata)
    );

    scc_ram #(.WIDTH(STK_W), .DEPTH(MAX_V)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata ({cur_v_reg, cur_e_reg + ECW'(1)}),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_finish_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (finish_total_reg[VW-1:0]),
        .wdata (cur_v_reg),
        .re    (f_re),
        .raddr (fi_reg[VW-1:0] - VW'(1)),
        .rdata (f_rdata)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_label_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (comp_cnt_reg[VW-1:0]),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg            <= N_MAX;
            edge_total_reg   <= '0;
            finish_total_reg <= '0;
            comp_cnt_reg     <= '0;
            sp_reg           <= '0;
            cur_v_reg        <= '0;
            cur_e_reg        <= '0;
            iv_reg           <= '0;
            fi_reg           <= '0;
            ov_reg           <= '0;
            vol_reg          <= '0;
            sink_reg         <= 1'b1;
            min_reg          <= '0;
            has_sink_reg     <= 1'b0;
            ans_reg          <= '0;
            pass_fwd_reg     <= 1'b1;
            seen_reg         <= '0;
            has_reg          <= '0;
            out_valid_reg    <= 1'b0;
            vertex_index     <= '0;
            component_label  <= '0;
            component_total  <= '0;
            min_sink_volume  <= '0;
            answer           <= '0;
            last             <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                n_reg <= cfg_clamped;
            if (out_fire)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_ADD_EDGE:
                begin
                    if (add_ok)
                        edge_total_reg <= edge_total_reg + ECW'(1);
                end
                OP_RUN_INIT:  iv_reg <= '0;
                OP_FWD_START:
                begin
                    seen_reg[iv_reg[VW-1:0]] <= 1'b1;
                    cur_v_reg    <= iv_reg[VW-1:0];
                    cur_e_reg    <= '0;
                    sp_reg       <= CNT_W'(1);
                    pass_fwd_reg <= 1'b1;
                end
                OP_FWD_SKIP:  iv_reg <= iv_reg + CNT_W'(1);
                OP_NEXT_EDGE: cur_e_reg <= cur_e_reg + ECW'(1);
                OP_PUSH:
                begin
                    if (pass_fwd_reg)
                        seen_reg[w] <= 1'b1;
                    else
                    begin
                        has_reg[w] <= 1'b1;
                        vol_reg    <= vol_reg + CNT_W'(1);
                    end
                    cur_v_reg <= w;
                    cur_e_reg <= '0;
                    sp_reg    <= sp_reg + CNT_W'(1);
                end
                OP_LABEL_CHK:
                begin
                    if (c_rdata != comp_cnt_reg[VW-1:0])
                        sink_reg <= 1'b0;
                    cur_e_reg <= cur_e_reg + ECW'(1);
                end
                OP_POP:
                begin
                    if (f_we)
                        finish_total_reg <= finish_total_reg + CNT_W'(1);
                    sp_reg <= sp_reg - CNT_W'(1);
                    if (sp_reg == CNT_W'(1))
                    begin
                        if (pass_fwd_reg)
                            iv_reg <= iv_reg + CNT_W'(1);
                        else
                        begin
                            if (sink_reg && (!has_sink_reg || (vol_reg < min_reg)))
                            begin
                                min_reg      <= vol_reg;
                                has_sink_reg <= 1'b1;
                            end
                            comp_cnt_reg <= comp_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                OP_RESTORE:
                begin
                    cur_v_reg <= s_rdata[STK_W-1:ECW];
                    cur_e_reg <= s_rdata[ECW-1:0];
                end
                OP_TR_INIT:   fi_reg <= finish_total_reg;
                OP_TR_RD:     fi_reg <= fi_reg - CNT_W'(1);
                OP_TR_START:
                begin
                    has_reg[f_rdata] <= 1'b1;
                    vol_reg      <= CNT_W'(1);
                    sink_reg     <= 1'b1;
                    cur_v_reg    <= f_rdata;
                    cur_e_reg    <= '0;
                    sp_reg       <= CNT_W'(1);
                    pass_fwd_reg <= 1'b0;
                end
                OP_ANS:
                begin
                    ans_reg <= has_sink_reg ? (n_reg - min_reg + CNT_W'(1)) : CNT_W'(1);
                    ov_reg  <= '0;
                end
                OP_OUT_LD:
                begin
                    out_valid_reg   <= 1'b1;
                    vertex_index    <= ov_reg;
                    component_label <= has_reg[ov_reg] ? c_rdata : '0;
                    component_total <= comp_cnt_reg;
                    min_sink_volume <= min_reg;
                    answer          <= ans_reg;
                    last            <= ({1'b0, ov_reg} == (n_reg - CNT_W'(1)));
                end
                OP_OUT_NEXT:  ov_reg <= ov_reg + VW'(1);
                OP_CLEAR:
                begin
                    edge_total_reg   <= '0;
                    finish_total_reg <= '0;
                    comp_cnt_reg     <= '0;
                    min_reg          <= '0;
                    has_sink_reg     <= 1'b0;
                    seen_reg         <= '0;
                    has_reg          <= '0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.edge_end   = (cur_e_reg >= edge_total_reg);
        stat.match      = usable && (pass_fwd_reg ? (e_src == cur_v_reg)
                                                  : (e_dst == cur_v_reg));
        stat.w_marked   = pass_fwd_reg ? seen_reg[w] : has_reg[w];
        stat.pass_fwd   = pass_fwd_reg;
        stat.sp_one     = (sp_reg == CNT_W'(1));
        stat.iv_done    = (iv_reg >= n_reg);
        stat.start_free = !seen_reg[iv_reg[VW-1:0]];
        stat.i_zero     = (fi_reg == '0);
        stat.u_has      = has_reg[f_rdata];
        stat.out_taken  = out_fire;
        stat.out_final  = ({1'b0, ov_reg} == (n_reg - CNT_W'(1)));
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_sp_bound, clk, rst_n, sp_reg > N_MAX)
    `ASSERT_NEVER(a_edge_bound, clk, rst_n, edge_total_reg > E_MAX)
    `ASSERT_AT(a_pop_nonempty, clk, rst_n, (cmd.op == OP_POP) |-> (sp_reg != '0))
endmodule

/* hw/rtl/scc_ctrl.sv */
// controller state machine sequencing loads, both walks and the result dump
module scc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  scc_pkg::dp_stat_t  stat,
    output scc_pkg::dp_cmd_t   cmd
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_OUTER,
        S_SCAN,
        S_CHECK,
        S_LABEL,
        S_RESTORE,
        S_TR_OUTER,
        S_TR_WAIT,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        cmd.op     = OP_RUN_INIT;
                        state_next = S_FWD_OUTER;
                    end
                    else
                        cmd.op = OP_ADD_EDGE;
                end
            end
            S_FWD_OUTER:
            begin
                if (stat.iv_done)
                begin
                    cmd.op     = OP_TR_INIT;
                    state_next = S_TR_OUTER;
                end
                else if (stat.start_free)
                begin
                    cmd.op     = OP_FWD_START;
                    state_next = S_SCAN;
                end
                else
                    cmd.op = OP_FWD_SKIP;
            end
            S_SCAN:
            begin
                if (stat.edge_end)
                begin
                    cmd.op = OP_POP;
                    if (!stat.sp_one)
                        state_next = S_RESTORE;
                    else if (stat.pass_fwd)
                        state_next = S_FWD_OUTER;
                    else
                        state_next = S_TR_OUTER;
                end
                else
                begin
                    cmd.op     = OP_SCAN;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_SCAN;
                if (!stat.match)
                    cmd.op = OP_NEXT_EDGE;
                else if (!stat.w_marked)
                    cmd.op = OP_PUSH;
                else if (stat.pass_fwd)
                    cmd.op = OP_NEXT_EDGE;
                else
                begin
                    cmd.op     = OP_COMP_RD;
                    state_next = S_LABEL;
                end
            end
            S_LABEL:
            begin
                cmd.op     = OP_LABEL_CHK;
                state_next = S_SCAN;
            end
            S_RESTORE:
            begin
                cmd.op     = OP_RESTORE;
                state_next = S_SCAN;
            end
            S_TR_OUTER:
            begin
                if (stat.i_zero)
                begin
                    cmd.op     = OP_ANS;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.op     = OP_TR_RD;
                    state_next = S_TR_WAIT;
                end
            end
            S_TR_WAIT:
            begin
                if (stat.u_has)
                    state_next = S_TR_OUTER;
                else
                begin
                    cmd.op     = OP_TR_START;
                    state_next = S_SCAN;
                end
            end
            S_OUT_RD:
            begin
                cmd.op     = OP_OUT_RD;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.op     = OP_OUT_LD;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.out_final)
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = OP_OUT_NEXT;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `include "assert_macros.svh"
    `ASSERT_AT(a_label_after_check, clk, rst_n, (state_reg == S_LABEL) |-> ($past(state_reg) == S_CHECK))
    `ASSERT_NEVER(a_taken_outside_wait, clk, rst_n, stat.out_taken && (state_reg != S_OUT_WAIT))
endmodule
